// File: sv/gkg_pkg.sv
// ----------------------------------------------------------------------------
// gkg_pkg
// Shared widths, register map, types and helpers of the gapped k-mer generator.
// ----------------------------------------------------------------------------
package gkg_pkg;

    localparam int GAP_W       = 5;
    localparam int NIB_W       = 4;
    localparam int KMER_W      = 64;
    localparam int POS_W       = 32;
    localparam int NIBBLES     = 16;
    localparam int GAP_LIMIT   = (1 << GAP_W) - 1;
    localparam int MAX_GAP_DEF = 31;
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_GAP_MIN = 2'd0;
    localparam t_reg_idx REG_GAP_MAX = 2'd1;
    localparam t_reg_idx REG_GAP_POS = 2'd2;

    typedef logic [GAP_W-1:0]  t_gap;
    typedef logic [NIB_W-1:0]  t_nib;
    typedef logic [KMER_W-1:0] t_kmer;
    typedef logic [POS_W-1:0]  t_pos;

    localparam t_gap RST_GAP_MIN = 5'd5;
    localparam t_gap RST_GAP_MAX = 5'd6;
    localparam t_nib RST_GAP_POS = 4'd6;

    typedef struct packed {
        t_gap gap_min;
        t_gap top;          // clamped gap_max, last slot of the ring
        t_nib gap_pos;
        logic gap_max_wr;   // gap_max written this cycle
    } t_cfg;

    typedef struct packed {
        t_kmer kmer;
        t_pos  pos;
        t_gap  wp;
        t_gap  next;
        logic  emit;
    } t_cmd;

    // set the low gap_pos nibbles
    function automatic t_kmer lead_mask(input t_nib pos);
        t_kmer m;
        m = '0;
        for (int b = 0; b < NIBBLES; b++) begin
            m[b*NIB_W +: NIB_W] = (b < int'(pos)) ? {NIB_W{1'b1}} : {NIB_W{1'b0}};
        end
        return m;
    endfunction

endpackage

// File: sv/gkg_if.sv
// ----------------------------------------------------------------------------
// gkg_in_if / gkg_out_if
// Valid/ready channels for k-mer items and gapped k-mer results.
// ----------------------------------------------------------------------------
interface gkg_in_if;
    logic          valid;
    logic          ready;
    gkg_pkg::t_kmer kmer_word;
    gkg_pkg::t_pos  start_position;

    modport source (output valid, output kmer_word, output start_position, input ready);
    modport sink   (input valid, input kmer_word, input start_position, output ready);
endinterface

interface gkg_out_if;
    logic          valid;
    logic          ready;
    gkg_pkg::t_kmer gapped_kmer;
    gkg_pkg::t_pos  lead_position;
    gkg_pkg::t_gap  gap_size;
    logic          last_of_run;

    modport source (output valid, output gapped_kmer, output lead_position,
                    output gap_size, output last_of_run, input ready);
    modport sink   (input valid, input gapped_kmer, input lead_position,
                    input gap_size, input last_of_run, output ready);
endinterface

// File: sv/gkg_cfg.sv
// ----------------------------------------------------------------------------
// gkg_cfg
// APB register file: gap_min, gap_max, gap_pos; clamps gap_max to MAX_GAP.
// ----------------------------------------------------------------------------
module gkg_cfg #(
    parameter int MAX_GAP = gkg_pkg::MAX_GAP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gkg_pkg::ADDR_W-1:0]  paddr,
    input  logic [gkg_pkg::DATA_W-1:0]  pwdata,
    output logic [gkg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output gkg_pkg::t_cfg               o_cfg
);

    gkg_pkg::t_gap     r_gap_min;
    gkg_pkg::t_gap     r_gap_max;
    gkg_pkg::t_nib     r_gap_pos;
    gkg_pkg::t_reg_idx idx;
    logic              wr;

    assign pready = 1'b1;
    assign idx    = paddr[gkg_pkg::ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_min <= gkg_pkg::RST_GAP_MIN;
            r_gap_max <= gkg_pkg::RST_GAP_MAX;
            r_gap_pos <= gkg_pkg::RST_GAP_POS;
        end else if (wr) begin
            unique case (idx)
                gkg_pkg::REG_GAP_MIN: r_gap_min <= pwdata[gkg_pkg::GAP_W-1:0];
                gkg_pkg::REG_GAP_MAX: r_gap_max <= pwdata[gkg_pkg::GAP_W-1:0];
                gkg_pkg::REG_GAP_POS: r_gap_pos <= pwdata[gkg_pkg::NIB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            gkg_pkg::REG_GAP_MIN: prdata = gkg_pkg::DATA_W'(r_gap_min);
            gkg_pkg::REG_GAP_MAX: prdata = gkg_pkg::DATA_W'(r_gap_max);
            gkg_pkg::REG_GAP_POS: prdata = gkg_pkg::DATA_W'(r_gap_pos);
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.gap_min    = r_gap_min;
        o_cfg.gap_pos    = r_gap_pos;
        o_cfg.gap_max_wr = wr && (idx == gkg_pkg::REG_GAP_MAX);
        if (int'(r_gap_max) > MAX_GAP) begin
            o_cfg.top = gkg_pkg::GAP_W'(MAX_GAP);
        end else begin
            o_cfg.top = r_gap_max;
        end
    end

endmodule

// File: sv/gkg_front.sv
// ----------------------------------------------------------------------------
// gkg_front
// Accepts k-mers, tracks the ring write pointer and fill state, and queues
// one command per item telling the back end where to store and what to emit.
// ----------------------------------------------------------------------------
module gkg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gkg_pkg::t_cfg i_cfg,
    gkg_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output gkg_pkg::t_cmd o_cmd
);

    gkg_pkg::t_gap r_wp;
    logic          r_full;
    gkg_pkg::t_gap n_wp;
    logic          wp_last;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    assign wp_last = (r_wp == i_cfg.top);
    assign n_wp    = wp_last ? '0 : r_wp + 1'b1;

    always_comb begin
        o_cmd.kmer = i_in.kmer_word;
        o_cmd.pos  = i_in.start_position;
        o_cmd.wp   = r_wp;
        o_cmd.next = n_wp;
        o_cmd.emit = (r_full || wp_last) && (i_cfg.gap_min != '0)
                     && (i_cfg.gap_min <= i_cfg.top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.gap_max_wr) begin
            // restart the ring at the new size
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (o_push) begin
            r_wp   <= n_wp;
            r_full <= r_full || wp_last;
        end
    end

endmodule

// File: sv/gkg_queue.sv
// ----------------------------------------------------------------------------
// gkg_queue
// Short command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module gkg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gkg_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output gkg_pkg::t_cmd o_cmd
);

    localparam int QP = (gkg_pkg::QUEUE_DEPTH > 1) ? $clog2(gkg_pkg::QUEUE_DEPTH) : 1;
    localparam int QC = $clog2(gkg_pkg::QUEUE_DEPTH + 1);

    gkg_pkg::t_cmd r_mem [gkg_pkg::QUEUE_DEPTH];
    logic [QP-1:0] r_wr_ptr;
    logic [QP-1:0] r_rd_ptr;
    logic [QC-1:0] r_count;

    assign o_full  = (r_count == QC'(gkg_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QP'(gkg_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QP'(gkg_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QC'(i_push) - QC'(i_pop);
        end
    end

endmodule

// File: sv/gkg_back.sv
// ----------------------------------------------------------------------------
// gkg_back
// Stores each item in the k-mer/position ring memories; if it emits, walks
// the gap sizes gap_min..top, reading lead and trail k-mers, one result each.
// ----------------------------------------------------------------------------
module gkg_back #(
    parameter int MAX_GAP = gkg_pkg::MAX_GAP_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gkg_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  gkg_pkg::t_cmd i_cmd,
    output logic          o_pop,
    gkg_out_if.source     o_out
);

    localparam int RING_DEPTH =
        ((MAX_GAP < gkg_pkg::GAP_LIMIT) ? MAX_GAP : gkg_pkg::GAP_LIMIT) + 1;
    localparam int PW = $clog2(RING_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WRITE = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;
    localparam logic [1:0] S_LOAD  = 2'd3;

    gkg_pkg::t_kmer r_kmer_mem [RING_DEPTH];
    gkg_pkg::t_pos  r_pos_mem  [RING_DEPTH];

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    gkg_pkg::t_cmd  r_cmd;
    gkg_pkg::t_gap  r_g;
    gkg_pkg::t_kmer r_lead_q;
    gkg_pkg::t_kmer r_trail_q;
    gkg_pkg::t_pos  r_lpos_q;

    logic           r_out_valid;
    gkg_pkg::t_kmer r_out_kmer;
    gkg_pkg::t_pos  r_out_pos;
    gkg_pkg::t_gap  r_out_gap;
    logic           r_out_last;

    logic                   out_free;
    logic                   g_last;
    logic                   rd_en;
    logic                   load;
    gkg_pkg::t_gap          rd_g;
    logic [gkg_pkg::GAP_W:0] sum;
    logic [gkg_pkg::GAP_W:0] size;
    logic [gkg_pkg::GAP_W:0] slot_w;
    logic [PW-1:0]          slot;
    gkg_pkg::t_kmer         lmask;

    assign out_free = !r_out_valid || o_out.ready;
    assign g_last   = (r_g == i_cfg.top);
    assign load     = (r_state == S_LOAD) && out_free;
    assign rd_en    = (r_state == S_ISSUE) || (load && !g_last);
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;

    // while unloading one result, read ahead for the next gap size
    assign rd_g   = (r_state == S_LOAD) ? r_g + 1'b1 : r_g;
    assign sum    = {1'b0, r_cmd.next} + {1'b0, rd_g};
    assign size   = {1'b0, i_cfg.top} + 1'b1;
    assign slot_w = (sum >= size) ? sum - size : sum;
    assign slot   = slot_w[PW-1:0];
    assign lmask  = gkg_pkg::lead_mask(i_cfg.gap_pos);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_q_valid) n_state = S_WRITE;
            S_WRITE: n_state = r_cmd.emit ? S_ISSUE : S_IDLE;
            S_ISSUE: n_state = S_LOAD;
            S_LOAD:  if (load && g_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_WRITE) begin
            r_g <= i_cfg.gap_min;
        end else if (load && !g_last) begin
            r_g <= r_g + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_kmer_mem[r_cmd.wp[PW-1:0]] <= r_cmd.kmer;
            r_pos_mem[r_cmd.wp[PW-1:0]]  <= r_cmd.pos;
        end
        if (rd_en) begin
            r_lead_q  <= r_kmer_mem[r_cmd.next[PW-1:0]];
            r_lpos_q  <= r_pos_mem[r_cmd.next[PW-1:0]];
            r_trail_q <= r_kmer_mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_kmer <= (r_lead_q & lmask) | (r_trail_q & ~lmask);
            r_out_pos  <= r_lpos_q;
            r_out_gap  <= r_g;
            r_out_last <= g_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.gapped_kmer   = r_out_kmer;
    assign o_out.lead_position = r_out_pos;
    assign o_out.gap_size      = r_out_gap;
    assign o_out.last_of_run   = r_out_last;

endmodule

// File: sv/gapped_kmer_generator.sv
// ----------------------------------------------------------------------------
// gapped_kmer_generator
// Gapped k-mer generator: ring of recent k-mers, one result per gap size.
// The first result of an item, with the back end idle, follows its input
// transfer through the command queue, pop, ring write, ring read and output register.
// Results come one per cycle while the output is not stalled, bound by the
// single ring memory walk; the back end pops no new item until a walk ends.
// A two-entry command queue lets input transfers continue during a walk.
// Reset (synchronous, active low) empties the ring and restores defaults.
// ----------------------------------------------------------------------------
module gapped_kmer_generator #(
    parameter int MAX_GAP = gkg_pkg::MAX_GAP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    gkg_in_if.sink                      i_in,
    gkg_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gkg_pkg::ADDR_W-1:0]  paddr,
    input  logic [gkg_pkg::DATA_W-1:0]  pwdata,
    output logic [gkg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    gkg_pkg::t_cfg cfg;
    gkg_pkg::t_cmd push_cmd;
    gkg_pkg::t_cmd pop_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;

    gkg_cfg #(.MAX_GAP(MAX_GAP)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gkg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    gkg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd)
    );

    gkg_back #(.MAX_GAP(MAX_GAP)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_cmd     (pop_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
